[hdl/dcp_pkg.sv]
// ============================================================================
// Disc collision physics step: shared package
// Types, constants and helper functions for the disc collision block.
// ============================================================================
package dcp_pkg;

    localparam int DATA_W     = 24;
    localparam int SIZE_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_IDX_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 15;
    localparam int GRAV_W     = 16;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int FRAC_BITS_DEF     = 8;

    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;
    localparam int WIDE_W = 56;
    localparam int RAD_W  = 50;
    localparam int ROOT_W = 25;
    localparam int QUOT_W = 17;
    localparam int NRM_W  = QUOT_W + 1;
    localparam int ITER_W = $clog2(ROOT_W);

    localparam int DRAG_Q16   = 65470;
    localparam int BOUNCE_Q16 = 58982;
    localparam int RND_SHIFT  = 16;
    localparam int NORM_SHIFT = 16;
    localparam int GRAV_SHIFT = 8;
    localparam int WALL_GAP   = 2;

    localparam logic [DIM_W-1:0]  WIDTH_RST   = 15'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RST  = 15'd480;
    localparam logic [GRAV_W-1:0] GRAVITY_RST = 16'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND,
        FUNC_CLEAR,
        FUNC_FRAME,
        FUNC_NOP
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_FULL,
        STATUS_EMPTY
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OUT,
        ST_I_RD,
        ST_I_LD,
        ST_I_DRAG,
        ST_I_DRAGW,
        ST_J_RD,
        ST_J_LD,
        ST_J_DX2,
        ST_J_DY2,
        ST_J_REACH,
        ST_J_CMP,
        ST_J_SQRT,
        ST_J_DIVX,
        ST_J_DIVY,
        ST_J_MV1,
        ST_J_MV2,
        ST_J_MV3,
        ST_J_ME1,
        ST_J_ME2,
        ST_J_ME3,
        ST_W_BY,
        ST_W_BX,
        ST_W_WR,
        ST_O_RD,
        ST_O_LD
    } state_t;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } rd_mode_t;

    typedef struct packed {
        logic     start;
        rd_mode_t mode;
    } rd_ctrl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic        [SIZE_W-1:0] size;
    } disc_t;

    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [DATA_W-1:0] r;
        hi = WIDE_W'(8388607);
        lo = -WIDE_W'(8388608);
        if (v > hi) begin
            r = 24'sh7FFFFF;
        end
        else if (v < lo) begin
            r = 24'sh800000;
        end
        else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [WIDE_W-1:0] round16(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] half;
        half = WIDE_W'(1 << (RND_SHIFT - 1));
        return (v + half) >>> RND_SHIFT;
    endfunction

endpackage

[hdl/dcp_mul.sv]
// ============================================================================
// Disc collision physics step: shared multiplier
// Signed multiplier with a registered product, one result per cycle.
// ============================================================================
module dcp_mul (
    input  logic                                clk,
    input  logic signed [dcp_pkg::MUL_W-1:0]    a,
    input  logic signed [dcp_pkg::MUL_W-1:0]    b,
    output logic signed [dcp_pkg::PROD_W-1:0]   p
);

    logic signed [dcp_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= dcp_pkg::PROD_W'(a) * dcp_pkg::PROD_W'(b);
    end

    assign p = p_reg;

endmodule

[hdl/dcp_rootdiv.sv]
// ============================================================================
// Disc collision physics step: root and divide unit
// Iterative integer square root and normal divider on one compare-subtract.
// ============================================================================
module dcp_rootdiv (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dcp_pkg::rd_ctrl_t                  ctrl,
    input  logic [dcp_pkg::RAD_W-1:0]          radicand,
    input  logic [dcp_pkg::ROOT_W-1:0]         num,
    input  logic [dcp_pkg::ROOT_W-1:0]         den,
    output logic                               busy,
    output logic [dcp_pkg::ROOT_W-1:0]         result
);

    localparam int REM_W = dcp_pkg::RAD_W + 1;

    logic                              busy_reg;
    logic                              busy_next;
    logic [dcp_pkg::ITER_W-1:0]        iter_reg;
    dcp_pkg::rd_mode_t                 mode_reg;
    logic [REM_W-1:0]                  rem_reg;
    logic [REM_W-1:0]                  rem_next;
    logic [REM_W-1:0]                  res_reg;
    logic [REM_W-1:0]                  res_next;
    logic [dcp_pkg::RAD_W-1:0]         bit_reg;
    logic [dcp_pkg::ROOT_W-1:0]        den_reg;
    logic [REM_W-1:0]                  sub;
    logic [REM_W-1:0]                  diff;
    logic                              ge;

    assign sub  = (mode_reg == dcp_pkg::RD_SQRT) ? res_reg + REM_W'(bit_reg)
                                                 : REM_W'(den_reg);
    assign ge   = rem_reg >= sub;
    assign diff = rem_reg - sub;

    always_comb
    begin
        if (mode_reg == dcp_pkg::RD_SQRT) begin
            rem_next = ge ? diff : rem_reg;
            res_next = ge ? (res_reg >> 1) + REM_W'(bit_reg) : (res_reg >> 1);
        end
        else begin
            rem_next = (ge ? diff : rem_reg) << 1;
            res_next = {res_reg[REM_W-2:0], ge};
        end
        busy_next = busy_reg && (iter_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (ctrl.start) begin
            busy_reg <= 1'b1;
            iter_reg <= (ctrl.mode == dcp_pkg::RD_SQRT) ?
                        dcp_pkg::ITER_W'(dcp_pkg::ROOT_W - 1) :
                        dcp_pkg::ITER_W'(dcp_pkg::QUOT_W - 1);
        end
        else if (busy_reg) begin
            busy_reg <= busy_next;
            iter_reg <= iter_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start) begin
            mode_reg <= ctrl.mode;
            den_reg  <= den;
            res_reg  <= '0;
            bit_reg  <= dcp_pkg::RAD_W'(1) << (dcp_pkg::RAD_W - 2);
            if (ctrl.mode == dcp_pkg::RD_SQRT) begin
                rem_reg <= REM_W'(radicand);
            end
            else begin
                rem_reg <= REM_W'(num);
            end
        end
        else if (busy_reg) begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy   = busy_reg;
    assign result = res_reg[dcp_pkg::ROOT_W-1:0];

endmodule

[hdl/disc_collision_physics_step.sv]
// ============================================================================
// Disc collision physics step: top level
// Disc table, frame sequencer, wall and gravity logic, output register.
// ============================================================================
// Append and clear give their word in the cycle after acceptance; a frame on an
// empty table does the same. A frame reads and updates each disc in turn, checks
// it against every other disc and resolves each overlapping pair with the
// 25-step square root and two 17-step divides on the shared root/divide unit,
// then reports each disc in turn. Input is stalled until all words are taken.
// Reset empties the table and loads the field registers with 640, 480 and 16.
module disc_collision_physics_step #(
    parameter int MAX_PARTICLES = dcp_pkg::MAX_PARTICLES_DEF,
    parameter int FRAC_BITS     = dcp_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [dcp_pkg::FUNC_W-1:0]            func,
    input  logic signed [dcp_pkg::DATA_W-1:0]     in_pos_x,
    input  logic signed [dcp_pkg::DATA_W-1:0]     in_pos_y,
    input  logic signed [dcp_pkg::DATA_W-1:0]     in_vel_x,
    input  logic signed [dcp_pkg::DATA_W-1:0]     in_vel_y,
    input  logic [dcp_pkg::SIZE_W-1:0]            in_diameter,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [dcp_pkg::OUT_IDX_W-1:0]         out_index,
    output logic signed [dcp_pkg::DATA_W-1:0]     out_pos_x,
    output logic signed [dcp_pkg::DATA_W-1:0]     out_pos_y,
    output logic signed [dcp_pkg::DATA_W-1:0]     out_vel_x,
    output logic signed [dcp_pkg::DATA_W-1:0]     out_vel_y,
    output logic [dcp_pkg::SIZE_W-1:0]            out_diameter,
    output logic [dcp_pkg::STATUS_W-1:0]          status,
    output logic                                  last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dcp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dcp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int IDX_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
    localparam int LIM_W  = (FRAC_BITS + 18 > 25) ? FRAC_BITS + 18 : 25;
    localparam int G_W    = dcp_pkg::GRAV_W + FRAC_BITS;
    localparam int DX_W   = dcp_pkg::DATA_W + 1;
    localparam int W      = dcp_pkg::WIDE_W;
    localparam int MW     = dcp_pkg::MUL_W;

    dcp_pkg::state_t               state_reg;
    dcp_pkg::state_t               state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              i_reg;
    logic [CNT_W-1:0]              j_reg;
    logic                          out_valid_reg;
    logic [dcp_pkg::DIM_W-1:0]     width_reg;
    logic [dcp_pkg::DIM_W-1:0]     height_reg;
    logic [dcp_pkg::GRAV_W-1:0]    grav_reg;

    dcp_pkg::disc_t                mem [MAX_PARTICLES];
    dcp_pkg::disc_t                rdata_reg;
    dcp_pkg::disc_t                mem_wdata;
    logic [IDX_W-1:0]              mem_addr;
    logic                          mem_we;

    logic signed [dcp_pkg::DATA_W-1:0] xp_reg;
    logic signed [dcp_pkg::DATA_W-1:0] yp_reg;
    logic signed [dcp_pkg::DATA_W-1:0] xs_reg;
    logic signed [dcp_pkg::DATA_W-1:0] ys_reg;
    logic [dcp_pkg::SIZE_W-1:0]        sz_reg;
    logic signed [dcp_pkg::DATA_W-1:0] cur_vx_reg;
    logic signed [dcp_pkg::DATA_W-1:0] cur_vy_reg;
    logic signed [dcp_pkg::DATA_W-1:0] by_reg;
    dcp_pkg::disc_t                    dj_reg;
    logic signed [DX_W-1:0]            dx_reg;
    logic signed [DX_W-1:0]            dy_reg;
    logic signed [dcp_pkg::PROD_W-1:0] acc_reg;
    logic [dcp_pkg::RAD_W-1:0]         d2_reg;
    logic [dcp_pkg::ROOT_W-1:0]        dist_reg;
    logic signed [dcp_pkg::NRM_W-1:0]  nx_reg;
    logic signed [dcp_pkg::NRM_W-1:0]  ny_reg;
    logic signed [MW-1:0]              dv_reg;
    logic signed [MW-1:0]              ex_reg;

    logic [dcp_pkg::OUT_IDX_W-1:0]     out_idx_reg;
    dcp_pkg::disc_t                    out_disc_reg;
    dcp_pkg::status_t                  status_reg;
    logic                              last_reg;

    logic signed [MW-1:0]              mul_a;
    logic signed [MW-1:0]              mul_b;
    logic signed [dcp_pkg::PROD_W-1:0] mul_p;
    dcp_pkg::rd_ctrl_t                 rd_ctrl;
    logic [dcp_pkg::ROOT_W-1:0]        rd_num;
    logic [dcp_pkg::ROOT_W-1:0]        rd_den;
    logic                              rd_busy;
    logic [dcp_pkg::ROOT_W-1:0]        rd_result;

    dcp_pkg::func_t                    func_in;
    logic                              in_accept;
    logic                              has_room;
    logic                              pair_skip;
    logic [dcp_pkg::PROD_W-1:0]        d2_sum;
    logic signed [W-1:0]               rnd_p;
    logic signed [W-1:0]               dv_rnd;
    logic [dcp_pkg::SIZE_W:0]          sz_sum;
    logic [DX_W-1:0]                   abs_dx;
    logic [DX_W-1:0]                   abs_dy;
    logic [dcp_pkg::QUOT_W-1:0]        quot;
    logic signed [dcp_pkg::NRM_W-1:0]  quot_s;
    logic signed [LIM_W-1:0]           lim_hy;
    logic signed [LIM_W-1:0]           lim_hx;
    logic signed [LIM_W-1:0]           lim_lo;
    logic signed [LIM_W-1:0]           xp_l;
    logic signed [LIM_W-1:0]           yp_l;
    logic                              hit_yhi;
    logic                              hit_ylo;
    logic                              hit_xhi;
    logic                              hit_xlo;
    logic [G_W-1:0]                    g_full;
    logic signed [W-1:0]               g_wide;
    logic signed [dcp_pkg::DATA_W-1:0] pos_x_fin;
    logic signed [dcp_pkg::DATA_W-1:0] pos_y_fin;
    logic signed [dcp_pkg::DATA_W-1:0] vx_fin;
    logic signed [dcp_pkg::DATA_W-1:0] vy_pre;
    logic signed [dcp_pkg::DATA_W-1:0] vy_fin;

    dcp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    dcp_rootdiv u_rootdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (rd_ctrl),
        .radicand (d2_reg),
        .num      (rd_num),
        .den      (rd_den),
        .busy     (rd_busy),
        .result   (rd_result)
    );

    assign func_in   = dcp_pkg::func_t'(func);
    assign in_stall  = (state_reg != dcp_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign has_room  = count_reg < CNT_W'(MAX_PARTICLES);
    assign cfg_ready = 1'b1;

    assign d2_sum    = acc_reg + mul_p;
    assign rnd_p     = dcp_pkg::round16(W'(mul_p));
    assign dv_rnd    = dcp_pkg::round16(W'(acc_reg) + W'(mul_p));
    assign sz_sum    = {1'b0, sz_reg} + {1'b0, dj_reg.size};
    assign pair_skip = (d2_reg == '0) ||
                       ({d2_reg, 2'b00} >= {2'b00, mul_p[dcp_pkg::RAD_W-1:0]});
    assign abs_dx    = dx_reg[DX_W-1] ? DX_W'(-dx_reg) : DX_W'(dx_reg);
    assign abs_dy    = dy_reg[DX_W-1] ? DX_W'(-dy_reg) : DX_W'(dy_reg);
    assign quot      = rd_result[dcp_pkg::QUOT_W-1:0];
    assign quot_s    = $signed({1'b0, quot});

    assign lim_hy = (LIM_W'({1'b0, height_reg}) - LIM_W'({1'b0, sz_reg})
                     + LIM_W'(dcp_pkg::WALL_GAP)) <<< FRAC_BITS;
    assign lim_hx = (LIM_W'({1'b0, width_reg}) - LIM_W'({1'b0, sz_reg})
                     + LIM_W'(dcp_pkg::WALL_GAP)) <<< FRAC_BITS;
    assign lim_lo = (LIM_W'({1'b0, sz_reg}) + LIM_W'(dcp_pkg::WALL_GAP)) <<< FRAC_BITS;
    assign xp_l   = LIM_W'(xp_reg);
    assign yp_l   = LIM_W'(yp_reg);
    assign hit_yhi = yp_l > lim_hy;
    assign hit_ylo = yp_l < lim_lo;
    assign hit_xhi = xp_l > lim_hx;
    assign hit_xlo = xp_l < lim_lo;

    assign g_full = {grav_reg, {FRAC_BITS{1'b0}}} >> dcp_pkg::GRAV_SHIFT;
    assign g_wide = W'(g_full);

    assign pos_y_fin = hit_ylo ? dcp_pkg::sat24(W'(lim_lo)) :
                       hit_yhi ? dcp_pkg::sat24(W'(lim_hy)) :
                       dcp_pkg::sat24(W'(yp_reg) + W'(ys_reg));
    assign pos_x_fin = hit_xlo ? dcp_pkg::sat24(W'(lim_lo)) :
                       hit_xhi ? dcp_pkg::sat24(W'(lim_hx)) :
                       dcp_pkg::sat24(W'(xp_reg) + W'(xs_reg));
    assign vy_pre    = (hit_ylo || hit_yhi) ? by_reg : cur_vy_reg;
    assign vy_fin    = dcp_pkg::sat24(W'(vy_pre) - g_wide);
    assign vx_fin    = (hit_xlo || hit_xhi) ? dcp_pkg::sat24(rnd_p) : cur_vx_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dcp_pkg::ST_IDLE: begin
                if (in_valid) begin
                    unique case (func_in)
                        dcp_pkg::FUNC_FRAME:
                            state_next = (count_reg == '0) ? dcp_pkg::ST_OUT : dcp_pkg::ST_I_RD;
                        dcp_pkg::FUNC_NOP:
                            state_next = dcp_pkg::ST_IDLE;
                        default:
                            state_next = dcp_pkg::ST_OUT;
                    endcase
                end
            end
            dcp_pkg::ST_OUT: begin
                if (!out_stall) begin
                    state_next = last_reg ? dcp_pkg::ST_IDLE : dcp_pkg::ST_O_RD;
                end
            end
            dcp_pkg::ST_I_RD:    state_next = dcp_pkg::ST_I_LD;
            dcp_pkg::ST_I_LD:    state_next = dcp_pkg::ST_I_DRAG;
            dcp_pkg::ST_I_DRAG:  state_next = dcp_pkg::ST_I_DRAGW;
            dcp_pkg::ST_I_DRAGW: state_next = dcp_pkg::ST_J_RD;
            dcp_pkg::ST_J_RD: begin
                if (j_reg == count_reg) begin
                    state_next = dcp_pkg::ST_W_BY;
                end
                else if (j_reg != i_reg) begin
                    state_next = dcp_pkg::ST_J_LD;
                end
            end
            dcp_pkg::ST_J_LD:    state_next = dcp_pkg::ST_J_DX2;
            dcp_pkg::ST_J_DX2:   state_next = dcp_pkg::ST_J_DY2;
            dcp_pkg::ST_J_DY2:   state_next = dcp_pkg::ST_J_REACH;
            dcp_pkg::ST_J_REACH: state_next = dcp_pkg::ST_J_CMP;
            dcp_pkg::ST_J_CMP:
                state_next = pair_skip ? dcp_pkg::ST_J_RD : dcp_pkg::ST_J_SQRT;
            dcp_pkg::ST_J_SQRT: begin
                if (!rd_busy) begin
                    state_next = dcp_pkg::ST_J_DIVX;
                end
            end
            dcp_pkg::ST_J_DIVX: begin
                if (!rd_busy) begin
                    state_next = dcp_pkg::ST_J_DIVY;
                end
            end
            dcp_pkg::ST_J_DIVY: begin
                if (!rd_busy) begin
                    state_next = dcp_pkg::ST_J_MV1;
                end
            end
            dcp_pkg::ST_J_MV1:   state_next = dcp_pkg::ST_J_MV2;
            dcp_pkg::ST_J_MV2:   state_next = dcp_pkg::ST_J_MV3;
            dcp_pkg::ST_J_MV3:   state_next = dcp_pkg::ST_J_ME1;
            dcp_pkg::ST_J_ME1:   state_next = dcp_pkg::ST_J_ME2;
            dcp_pkg::ST_J_ME2:   state_next = dcp_pkg::ST_J_ME3;
            dcp_pkg::ST_J_ME3:   state_next = dcp_pkg::ST_J_RD;
            dcp_pkg::ST_W_BY:    state_next = dcp_pkg::ST_W_BX;
            dcp_pkg::ST_W_BX:    state_next = dcp_pkg::ST_W_WR;
            dcp_pkg::ST_W_WR:
                state_next = (i_reg + 1'b1 == count_reg) ? dcp_pkg::ST_O_RD : dcp_pkg::ST_I_RD;
            dcp_pkg::ST_O_RD:    state_next = dcp_pkg::ST_O_LD;
            dcp_pkg::ST_O_LD:    state_next = dcp_pkg::ST_OUT;
            default:             state_next = dcp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a         = '0;
        mul_b         = '0;
        mem_we        = 1'b0;
        mem_addr      = i_reg[IDX_W-1:0];
        mem_wdata     = dj_reg;
        rd_ctrl.start = 1'b0;
        rd_ctrl.mode  = dcp_pkg::RD_DIV;
        rd_num        = abs_dx;
        rd_den        = dist_reg;
        unique case (state_reg)
            dcp_pkg::ST_IDLE: begin
                mem_addr        = count_reg[IDX_W-1:0];
                mem_we          = in_accept && (func_in == dcp_pkg::FUNC_APPEND) && has_room;
                mem_wdata.pos_x = in_pos_x;
                mem_wdata.pos_y = in_pos_y;
                mem_wdata.vel_x = in_vel_x;
                mem_wdata.vel_y = in_vel_y;
                mem_wdata.size  = in_diameter;
            end
            dcp_pkg::ST_I_DRAG: begin
                mul_a = MW'(xs_reg);
                mul_b = MW'(dcp_pkg::DRAG_Q16);
            end
            dcp_pkg::ST_J_RD: begin
                mem_addr = j_reg[IDX_W-1:0];
            end
            dcp_pkg::ST_J_DX2: begin
                mul_a = MW'(dx_reg);
                mul_b = MW'(dx_reg);
            end
            dcp_pkg::ST_J_DY2: begin
                mul_a = MW'(dy_reg);
                mul_b = MW'(dy_reg);
            end
            dcp_pkg::ST_J_REACH: begin
                mul_a = MW'(sz_sum) <<< FRAC_BITS;
                mul_b = MW'(sz_sum) <<< FRAC_BITS;
            end
            dcp_pkg::ST_J_CMP: begin
                rd_ctrl.start = !pair_skip;
                rd_ctrl.mode  = dcp_pkg::RD_SQRT;
            end
            dcp_pkg::ST_J_SQRT: begin
                rd_ctrl.start = !rd_busy;
                rd_num        = abs_dx;
                rd_den        = rd_result;
            end
            dcp_pkg::ST_J_DIVX: begin
                rd_ctrl.start = !rd_busy;
                rd_num        = abs_dy;
            end
            dcp_pkg::ST_J_MV1: begin
                mul_a = MW'(xs_reg) - MW'(dj_reg.vel_x);
                mul_b = MW'(nx_reg);
            end
            dcp_pkg::ST_J_MV2: begin
                mul_a = MW'(ys_reg) - MW'(dj_reg.vel_y);
                mul_b = MW'(ny_reg);
            end
            dcp_pkg::ST_J_ME1: begin
                mul_a = dv_reg;
                mul_b = MW'(nx_reg);
            end
            dcp_pkg::ST_J_ME2: begin
                mul_a = dv_reg;
                mul_b = MW'(ny_reg);
            end
            dcp_pkg::ST_J_ME3: begin
                mem_addr        = j_reg[IDX_W-1:0];
                mem_we          = 1'b1;
                mem_wdata.vel_x = dcp_pkg::sat24(W'(dj_reg.vel_x) + W'(ex_reg));
                mem_wdata.vel_y = dcp_pkg::sat24(W'(dj_reg.vel_y) + rnd_p);
            end
            dcp_pkg::ST_W_BY: begin
                mul_a = -MW'(ys_reg);
                mul_b = MW'(dcp_pkg::BOUNCE_Q16);
            end
            dcp_pkg::ST_W_BX: begin
                mul_a = -MW'(xs_reg);
                mul_b = MW'(dcp_pkg::BOUNCE_Q16);
            end
            dcp_pkg::ST_W_WR: begin
                mem_we          = 1'b1;
                mem_wdata.pos_x = pos_x_fin;
                mem_wdata.pos_y = pos_y_fin;
                mem_wdata.vel_x = vx_fin;
                mem_wdata.vel_y = vy_fin;
                mem_wdata.size  = sz_reg;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= dcp_pkg::ST_IDLE;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= dcp_pkg::WIDTH_RST;
            height_reg    <= dcp_pkg::HEIGHT_RST;
            grav_reg      <= dcp_pkg::GRAVITY_RST;
        end
        else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    dcp_pkg::CFG_WIDTH:   width_reg  <= cfg_data[dcp_pkg::DIM_W-1:0];
                    dcp_pkg::CFG_HEIGHT:  height_reg <= cfg_data[dcp_pkg::DIM_W-1:0];
                    dcp_pkg::CFG_GRAVITY: grav_reg   <= cfg_data;
                    default:              grav_reg   <= grav_reg;
                endcase
            end
            unique case (state_reg)
                dcp_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        i_reg <= '0;
                        unique case (func_in)
                            dcp_pkg::FUNC_APPEND: begin
                                if (has_room) begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                out_valid_reg <= 1'b1;
                            end
                            dcp_pkg::FUNC_CLEAR: begin
                                count_reg     <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            dcp_pkg::FUNC_FRAME: out_valid_reg <= (count_reg == '0);
                            default:             out_valid_reg <= 1'b0;
                        endcase
                    end
                end
                dcp_pkg::ST_OUT: begin
                    if (!out_stall) begin
                        out_valid_reg <= 1'b0;
                        if (!last_reg) begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                dcp_pkg::ST_I_DRAGW: j_reg <= '0;
                dcp_pkg::ST_J_RD: begin
                    if ((j_reg != count_reg) && (j_reg == i_reg)) begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                dcp_pkg::ST_J_CMP: begin
                    if (pair_skip) begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                dcp_pkg::ST_J_ME3: j_reg <= j_reg + 1'b1;
                dcp_pkg::ST_W_WR: begin
                    i_reg <= (i_reg + 1'b1 == count_reg) ? '0 : i_reg + 1'b1;
                end
                dcp_pkg::ST_O_LD: out_valid_reg <= 1'b1;
                default: begin
                    out_valid_reg <= out_valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            dcp_pkg::ST_IDLE: begin
                out_idx_reg  <= '0;
                out_disc_reg <= '0;
                last_reg     <= 1'b1;
                status_reg   <= dcp_pkg::STATUS_OK;
                if (func_in == dcp_pkg::FUNC_APPEND) begin
                    if (has_room) begin
                        out_idx_reg        <= dcp_pkg::OUT_IDX_W'(count_reg);
                        out_disc_reg.pos_x <= in_pos_x;
                        out_disc_reg.pos_y <= in_pos_y;
                        out_disc_reg.vel_x <= in_vel_x;
                        out_disc_reg.vel_y <= in_vel_y;
                        out_disc_reg.size  <= in_diameter;
                    end
                    else begin
                        status_reg <= dcp_pkg::STATUS_FULL;
                    end
                end
                else if (func_in == dcp_pkg::FUNC_FRAME) begin
                    status_reg <= dcp_pkg::STATUS_EMPTY;
                end
            end
            dcp_pkg::ST_I_LD: begin
                xp_reg <= rdata_reg.pos_x;
                yp_reg <= rdata_reg.pos_y;
                xs_reg <= rdata_reg.vel_x;
                ys_reg <= rdata_reg.vel_y;
                sz_reg <= rdata_reg.size;
            end
            dcp_pkg::ST_I_DRAGW: begin
                cur_vx_reg <= dcp_pkg::sat24(rnd_p);
                cur_vy_reg <= ys_reg;
            end
            dcp_pkg::ST_J_LD: begin
                dj_reg <= rdata_reg;
                dx_reg <= DX_W'(rdata_reg.pos_x) - DX_W'(xp_reg);
                dy_reg <= DX_W'(rdata_reg.pos_y) - DX_W'(yp_reg);
            end
            dcp_pkg::ST_J_DY2:   acc_reg <= mul_p;
            dcp_pkg::ST_J_REACH: d2_reg  <= d2_sum[dcp_pkg::RAD_W-1:0];
            dcp_pkg::ST_J_SQRT: begin
                if (!rd_busy) begin
                    dist_reg <= rd_result;
                end
            end
            dcp_pkg::ST_J_DIVX: begin
                if (!rd_busy) begin
                    nx_reg <= dx_reg[DX_W-1] ? -quot_s : quot_s;
                end
            end
            dcp_pkg::ST_J_DIVY: begin
                if (!rd_busy) begin
                    ny_reg <= dy_reg[DX_W-1] ? -quot_s : quot_s;
                end
            end
            dcp_pkg::ST_J_MV2: acc_reg <= mul_p;
            dcp_pkg::ST_J_MV3: dv_reg  <= dv_rnd[MW-1:0];
            dcp_pkg::ST_J_ME2: ex_reg  <= rnd_p[MW-1:0];
            dcp_pkg::ST_J_ME3: begin
                cur_vx_reg <= dcp_pkg::sat24(W'(xs_reg) - W'(ex_reg));
                cur_vy_reg <= dcp_pkg::sat24(W'(ys_reg) - rnd_p);
            end
            dcp_pkg::ST_W_BX: by_reg <= dcp_pkg::sat24(rnd_p);
            dcp_pkg::ST_O_LD: begin
                out_idx_reg  <= dcp_pkg::OUT_IDX_W'(i_reg);
                out_disc_reg <= rdata_reg;
                status_reg   <= dcp_pkg::STATUS_OK;
                last_reg     <= (i_reg + 1'b1 == count_reg);
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_index    = out_idx_reg;
    assign out_pos_x    = out_disc_reg.pos_x;
    assign out_pos_y    = out_disc_reg.pos_y;
    assign out_vel_x    = out_disc_reg.vel_x;
    assign out_vel_y    = out_disc_reg.vel_y;
    assign out_diameter = out_disc_reg.size;
    assign status       = status_reg;
    assign last         = last_reg;

    // The table never holds more discs than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTICLES))
        else $error("disc count above table size");

    // A word is only shown while the sequencer waits on the output.
    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == dcp_pkg::ST_OUT))
        else $error("output word shown outside the output state");

    // The root and divide unit is never restarted while it is still working.
    a_rd_start: assert property (@(posedge clk) disable iff (!rst_n)
        rd_ctrl.start |-> !rd_busy)
        else $error("root/divide unit started while busy");

    // An append that finds room grows the table by exactly one disc.
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (func_in == dcp_pkg::FUNC_APPEND) && has_room)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not grow the table");

endmodule
